// ----- hdl/swt_pkg.sv -----
// ----------------------------------------------------------------------------
// swt_pkg: shared types and constants for the send window table
// Window geometry, item codes, status codes and the packed record layout.
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int BUFFER_BYTES = 65536;
    localparam int MAX_SEGMENT  = 1024;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    localparam int KIND_W   = 2;
    localparam int SEQ_W    = 32;
    localparam int OFFSET_W = 16;
    localparam int BYTES_W  = 11;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SHIFT_W  = 5;
    localparam int OCC_W    = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [OFFSET_W-1:0] offset;
        logic [BYTES_W-1:0]  bytes;
        logic [TIME_W-1:0]   stamp;
    } t_rec;

    // Ring successor; wraps at the window depth, which need not be a power of two.
    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(WINDOW_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + IDX_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ----- hdl/swt_rec_ram.sv -----
// ----------------------------------------------------------------------------
// swt_rec_ram: packet record memory
// Single port, one address per cycle (a write also reads the old word), registered read data.
// ----------------------------------------------------------------------------
module swt_rec_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [swt_pkg::IDX_W-1:0] i_addr,
    input  swt_pkg::t_rec            i_wdata,
    output swt_pkg::t_rec            o_rdata
);

    swt_pkg::t_rec r_mem [swt_pkg::WINDOW_DEPTH];
    swt_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/send_window_table_top.sv -----
// ----------------------------------------------------------------------------
// send_window_table_top: circular sender window of packet records
// Insert at the tail, ack with head advance, lookup by sequence number.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes S_EXEC, then S_HEAD and S_HOUT (head record read)
//   before the result is valid; an ack/lookup on a nonempty window first scans from the head,
//   through S_SRD and S_SCMP for each slot, and a matching ack then advances the head
//   in S_ADV over the acked slots. The scan loop runs over the single-port record memory.
// Throughput: one item at a time; the next item is taken after the result leaves.
// Reset: synchronous active-low clears head, tail, count, ack bits and handshake.
module send_window_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [swt_pkg::KIND_W-1:0]    i_kind,
    input  logic [swt_pkg::SEQ_W-1:0]     i_seq_number,
    input  logic [swt_pkg::OFFSET_W-1:0]  i_buffer_offset,
    input  logic [swt_pkg::BYTES_W-1:0]   i_packet_bytes,
    input  logic [swt_pkg::TIME_W-1:0]    i_send_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [swt_pkg::STATUS_W-1:0]  o_status,
    output logic [swt_pkg::SHIFT_W-1:0]   o_head_shift,
    output logic [swt_pkg::OFFSET_W-1:0]  o_found_offset,
    output logic [swt_pkg::BYTES_W-1:0]   o_found_bytes,
    output logic [swt_pkg::TIME_W-1:0]    o_found_time,
    output logic [swt_pkg::SEQ_W-1:0]     o_oldest_seq,
    output logic [swt_pkg::OCC_W-1:0]     o_occupancy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCMP = 3'd3;
    localparam logic [2:0] S_ADV  = 3'd4;
    localparam logic [2:0] S_HEAD = 3'd5;
    localparam logic [2:0] S_HOUT = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]                    r_state;
    logic [swt_pkg::IDX_W-1:0]     r_head;
    logic [swt_pkg::IDX_W-1:0]     r_tail;
    logic [swt_pkg::CNT_W-1:0]     r_count;
    logic [swt_pkg::IDX_W-1:0]     r_idx;
    logic [swt_pkg::CNT_W-1:0]     r_k;
    logic [swt_pkg::WINDOW_DEPTH-1:0] r_acked;

    logic [swt_pkg::KIND_W-1:0]    r_kind;
    swt_pkg::t_rec                 r_in;

    logic                          r_out_valid;
    logic [swt_pkg::STATUS_W-1:0]  r_status;
    logic [swt_pkg::SHIFT_W-1:0]   r_shift;
    logic [swt_pkg::OFFSET_W-1:0]  r_f_offset;
    logic [swt_pkg::BYTES_W-1:0]   r_f_bytes;
    logic [swt_pkg::TIME_W-1:0]    r_f_time;
    logic [swt_pkg::SEQ_W-1:0]     r_oldest;

    logic                          ram_we;
    logic [swt_pkg::IDX_W-1:0]     ram_addr;
    swt_pkg::t_rec                 ram_rdata;
    logic [swt_pkg::BYTES_W-1:0]   clamp_bytes;
    logic                          scan_hit;

    swt_rec_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_in),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (32'(i_packet_bytes) > swt_pkg::MAX_SEGMENT) begin
            clamp_bytes = swt_pkg::BYTES_W'(swt_pkg::MAX_SEGMENT);
        end else begin
            clamp_bytes = i_packet_bytes;
        end
    end

    // Single shared compare: live slot whose stored number matches the item.
    assign scan_hit = !r_acked[r_idx] && (ram_rdata.seq == r_in.seq);

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = r_head;
        unique case (r_state)
            S_EXEC: begin
                ram_addr = r_tail;
                ram_we   = (r_kind == swt_pkg::KIND_INSERT) &&
                           (r_count < swt_pkg::CNT_W'(swt_pkg::WINDOW_DEPTH));
            end
            S_SRD, S_SCMP: ram_addr = r_idx;
            default: ram_addr = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_acked     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind       <= i_kind;
                        r_in.seq     <= i_seq_number;
                        r_in.offset  <= i_buffer_offset;
                        r_in.bytes   <= clamp_bytes;
                        r_in.stamp   <= i_send_time;
                        r_status     <= swt_pkg::ST_OK;
                        r_shift      <= '0;
                        r_f_offset   <= '0;
                        r_f_bytes    <= '0;
                        r_f_time     <= '0;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_kind == swt_pkg::KIND_INSERT) begin
                        r_state <= S_HEAD;
                        if (r_count >= swt_pkg::CNT_W'(swt_pkg::WINDOW_DEPTH)) begin
                            r_status <= swt_pkg::ST_FULL;
                        end else begin
                            r_acked[r_tail] <= 1'b0;
                            r_tail          <= swt_pkg::f_next(r_tail);
                            r_count         <= r_count + swt_pkg::CNT_W'(1);
                        end
                    end else if (r_kind == swt_pkg::KIND_ACK ||
                                 r_kind == swt_pkg::KIND_LOOKUP) begin
                        if (r_count == '0) begin
                            r_status <= swt_pkg::ST_EMPTY;
                            r_state  <= S_HEAD;
                        end else begin
                            r_idx   <= r_head;
                            r_k     <= '0;
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_state <= S_HEAD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (scan_hit) begin
                        if (r_kind == swt_pkg::KIND_LOOKUP) begin
                            r_f_offset <= ram_rdata.offset;
                            r_f_bytes  <= ram_rdata.bytes;
                            r_f_time   <= ram_rdata.stamp;
                            r_state    <= S_HEAD;
                        end else begin
                            r_acked[r_idx] <= 1'b1;
                            r_state        <= S_ADV;
                        end
                    end else if ((r_k + swt_pkg::CNT_W'(1)) == r_count) begin
                        r_status <= swt_pkg::ST_MISS;
                        r_state  <= S_HEAD;
                    end else begin
                        r_k     <= r_k + swt_pkg::CNT_W'(1);
                        r_idx   <= swt_pkg::f_next(r_idx);
                        r_state <= S_SRD;
                    end
                end
                S_ADV: begin
                    // advance the head one acked slot per cycle
                    if ((r_count != '0) && r_acked[r_head]) begin
                        r_head  <= swt_pkg::f_next(r_head);
                        r_count <= r_count - swt_pkg::CNT_W'(1);
                        r_shift <= r_shift + swt_pkg::SHIFT_W'(1);
                    end else begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_state <= S_HOUT;
                end
                S_HOUT: begin
                    r_oldest    <= (r_count != '0) ? ram_rdata.seq : '0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_head_shift   = r_shift;
    assign o_found_offset = r_f_offset;
    assign o_found_bytes  = r_f_bytes;
    assign o_found_time   = r_f_time;
    assign o_oldest_seq   = r_oldest;
    assign o_occupancy    = swt_pkg::OCC_W'(r_count);

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= swt_pkg::CNT_W'(swt_pkg::WINDOW_DEPTH))
        else $error("window count above depth");

    a_ring_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == swt_pkg::CNT_W'(swt_pkg::WINDOW_DEPTH))
        |-> (r_head == r_tail))
        else $error("head and tail disagree with empty or full count");

    a_shift_ack_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_kind != swt_pkg::KIND_ACK) |-> (o_head_shift == '0))
        else $error("head shift reported on a non-ack item");

    a_empty_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_occupancy == '0) |-> (o_oldest_seq == '0))
        else $error("oldest sequence nonzero on empty window");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for send_window_table_top
// A table of directed items covers the empty, full, miss, duplicate and
// wrapping cases. Random packet traffic follows, in alternating fill and
// drain phases. Every result is checked against a table value or an in-bench window tracker.
// Both handshake sides stall at random, except in a steady stretch of the random phase.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [swt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [swt_pkg::KIND_W-1:0]   kind;
        logic [swt_pkg::SEQ_W-1:0]    seq;
        logic [swt_pkg::OFFSET_W-1:0] offs;
        logic [swt_pkg::BYTES_W-1:0]  bytes;
        logic [swt_pkg::TIME_W-1:0]   stime;
    } t_pkt_item;

    typedef struct packed {
        logic [swt_pkg::STATUS_W-1:0] status;
        logic [swt_pkg::SHIFT_W-1:0]  shift;
        logic [swt_pkg::OFFSET_W-1:0] f_off;
        logic [swt_pkg::BYTES_W-1:0]  f_bytes;
        logic [swt_pkg::TIME_W-1:0]   f_time;
        logic [swt_pkg::SEQ_W-1:0]    oldest;
        logic [swt_pkg::OCC_W-1:0]    occ;
    } t_window_result;

    typedef struct {
        t_pkt_item      item;
        int             reps;
        bit             typed;
        t_window_result want;
    } t_plan_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         i_out_ready = 1'b0;
    logic [swt_pkg::KIND_W-1:0]   i_kind = '0;
    logic [swt_pkg::SEQ_W-1:0]    i_seq_number = '0;
    logic [swt_pkg::OFFSET_W-1:0] i_buffer_offset = '0;
    logic [swt_pkg::BYTES_W-1:0]  i_packet_bytes = '0;
    logic [swt_pkg::TIME_W-1:0]   i_send_time = '0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [swt_pkg::STATUS_W-1:0] o_status;
    logic [swt_pkg::SHIFT_W-1:0]  o_head_shift;
    logic [swt_pkg::OFFSET_W-1:0] o_found_offset;
    logic [swt_pkg::BYTES_W-1:0]  o_found_bytes;
    logic [swt_pkg::TIME_W-1:0]   o_found_time;
    logic [swt_pkg::SEQ_W-1:0]    o_oldest_seq;
    logic [swt_pkg::OCC_W-1:0]    o_occupancy;

    // window tracker state
    logic [swt_pkg::SEQ_W-1:0]    win_seq    [swt_pkg::WINDOW_DEPTH];
    logic [swt_pkg::OFFSET_W-1:0] win_offset [swt_pkg::WINDOW_DEPTH];
    logic [swt_pkg::BYTES_W-1:0]  win_bytes  [swt_pkg::WINDOW_DEPTH];
    logic [swt_pkg::TIME_W-1:0]   win_time   [swt_pkg::WINDOW_DEPTH];
    bit                           win_acked  [swt_pkg::WINDOW_DEPTH] = '{default: 1'b0};
    int                           win_head = 0;
    int                           win_tail = 0;
    int                           win_count = 0;

    t_window_result               expected_q [$];
    t_plan_row                    plan [$];
    logic [swt_pkg::SEQ_W-1:0]    seq_cursor = 32'hFFFF_FF00;
    bit                           steady = 1'b0;
    int                           err_count = 0;
    int                           result_count = 0;
    int                           max_shift = 0;
    int                           cycle_count = 0;
    int                           kind_tally [4] = '{default: 0};
    int                           status_tally [4] = '{default: 0};

    send_window_table_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_seq_number    (i_seq_number),
        .i_buffer_offset (i_buffer_offset),
        .i_packet_bytes  (i_packet_bytes),
        .i_send_time     (i_send_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_head_shift    (o_head_shift),
        .o_found_offset  (o_found_offset),
        .o_found_bytes   (o_found_bytes),
        .o_found_time    (o_found_time),
        .o_oldest_seq    (o_oldest_seq),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int ring_next(input int idx);
        return (idx == swt_pkg::WINDOW_DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // Apply one item to the tracked window and return the result it causes.
    function automatic t_window_result window_step(input t_pkt_item it);
        t_window_result res;
        int idx;
        int hit;
        res = '0;
        hit = -1;
        case (it.kind)
            swt_pkg::KIND_INSERT: begin
                if (win_count >= swt_pkg::WINDOW_DEPTH) begin
                    res.status = swt_pkg::ST_FULL;
                end else begin
                    win_seq[win_tail]    = it.seq;
                    win_offset[win_tail] = it.offs;
                    win_bytes[win_tail]  = (it.bytes > swt_pkg::MAX_SEGMENT) ?
                                           swt_pkg::BYTES_W'(swt_pkg::MAX_SEGMENT) :
                                           it.bytes;
                    win_time[win_tail]   = it.stime;
                    win_acked[win_tail]  = 1'b0;
                    win_tail  = ring_next(win_tail);
                    win_count = win_count + 1;
                end
            end
            swt_pkg::KIND_ACK, swt_pkg::KIND_LOOKUP: begin
                if (win_count == 0) begin
                    res.status = swt_pkg::ST_EMPTY;
                end else begin
                    // take the unacked match nearest the head
                    idx = win_head;
                    for (int k = 0; k < win_count; k++) begin
                        if (hit < 0 && !win_acked[idx] && win_seq[idx] == it.seq) begin
                            hit = idx;
                        end
                        idx = ring_next(idx);
                    end
                    if (hit < 0) begin
                        res.status = swt_pkg::ST_MISS;
                    end else if (it.kind == swt_pkg::KIND_LOOKUP) begin
                        res.f_off   = win_offset[hit];
                        res.f_bytes = win_bytes[hit];
                        res.f_time  = win_time[hit];
                    end else begin
                        win_acked[hit] = 1'b1;
                        while (win_count > 0 && win_acked[win_head]) begin
                            win_head  = ring_next(win_head);
                            win_count = win_count - 1;
                            res.shift = res.shift + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.oldest = (win_count > 0) ? win_seq[win_head] : '0;
        res.occ    = swt_pkg::OCC_W'(win_count);
        return res;
    endfunction

    function automatic logic [swt_pkg::SEQ_W-1:0] live_window_seq();
        return win_seq[(win_head + int'($urandom_range(win_count - 1))) %
                       swt_pkg::WINDOW_DEPTH];
    endfunction

    // Mostly fresh inserts and acks/lookups of numbers in the window; some noise.
    function automatic t_pkt_item random_item(input bit filling);
        t_pkt_item it;
        int roll;
        it.kind  = swt_pkg::KIND_INSERT;
        it.seq   = $urandom;
        it.offs  = swt_pkg::OFFSET_W'($urandom);
        it.stime = $urandom;
        it.bytes = ($urandom_range(99) < 8) ?
                   swt_pkg::BYTES_W'($urandom_range(2047, 1025)) :
                   swt_pkg::BYTES_W'($urandom_range(1024, 0));
        roll = $urandom_range(99);
        if (roll < 2) begin
            it.kind = KIND_UNUSED;
        end else if (roll < (filling ? 65 : 30)) begin
            roll = $urandom_range(99);
            if (roll < 10 && win_count > 0) begin
                it.seq = live_window_seq();
            end else if (roll < 95) begin
                it.seq     = seq_cursor;
                seq_cursor = seq_cursor + 1'b1;
            end
        end else begin
            it.kind = ($urandom_range(99) < 70) ? swt_pkg::KIND_ACK : swt_pkg::KIND_LOOKUP;
            if (win_count > 0 && $urandom_range(99) < 85) begin
                it.seq = live_window_seq();
            end else if ($urandom_range(1) == 1) begin
                it.seq = seq_cursor;
            end
        end
        return it;
    endfunction

    function automatic t_plan_row row(
        input logic [swt_pkg::KIND_W-1:0] k, input logic [swt_pkg::SEQ_W-1:0] s,
        input logic [swt_pkg::OFFSET_W-1:0] o, input logic [swt_pkg::BYTES_W-1:0] b,
        input logic [swt_pkg::TIME_W-1:0] t, input int reps = 1);
        t_plan_row p;
        p.item  = '{k, s, o, b, t};
        p.reps  = reps;
        p.typed = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    function automatic t_plan_row trow(
        input logic [swt_pkg::KIND_W-1:0] k, input logic [swt_pkg::SEQ_W-1:0] s,
        input logic [swt_pkg::OFFSET_W-1:0] o, input logic [swt_pkg::BYTES_W-1:0] b,
        input logic [swt_pkg::TIME_W-1:0] t,
        input logic [swt_pkg::STATUS_W-1:0] st, input logic [swt_pkg::SHIFT_W-1:0] sh,
        input logic [swt_pkg::OFFSET_W-1:0] fo, input logic [swt_pkg::BYTES_W-1:0] fb,
        input logic [swt_pkg::TIME_W-1:0] ft, input logic [swt_pkg::SEQ_W-1:0] old,
        input logic [swt_pkg::OCC_W-1:0] occ);
        t_plan_row p;
        p       = row(k, s, o, b, t);
        p.typed = 1'b1;
        p.want  = '{st, sh, fo, fb, ft, old, occ};
        return p;
    endfunction

    function automatic void log_fault(input string msg);
        err_count = err_count + 1;
        if (err_count <= REPORT_MAX) begin
            $display("ERROR @%0d: %s", cycle_count, msg);
        end
    endfunction

    task automatic send_item(input t_pkt_item it);
        if (!steady && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= it.kind;
        i_seq_number    <= it.seq;
        i_buffer_offset <= it.offs;
        i_packet_bytes  <= it.bytes;
        i_send_time     <= it.stime;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        kind_tally[it.kind] = kind_tally[it.kind] + 1;
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("send_window_table_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_window_result got;
        t_window_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_head_shift, o_found_offset, o_found_bytes,
                    o_found_time, o_oldest_seq, o_occupancy};
            if (expected_q.size() == 0) begin
                log_fault($sformatf("result with nothing pending: status %0d occupancy %0d",
                                    got.status, got.occ));
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    log_fault($sformatf({"result %0d: status %0d/%0d shift %0d/%0d ",
                        "offset %h/%h bytes %0d/%0d time %h/%h oldest %h/%h ",
                        "occupancy %0d/%0d (expected/actual)"},
                        result_count, want.status, got.status, want.shift, got.shift,
                        want.f_off, got.f_off, want.f_bytes, got.f_bytes,
                        want.f_time, got.f_time, want.oldest, got.oldest,
                        want.occ, got.occ));
                end
            end
            result_count = result_count + 1;
            status_tally[got.status] = status_tally[got.status] + 1;
            if (int'(got.shift) > max_shift) begin
                max_shift = int'(got.shift);
            end
        end
    end

    initial begin
        t_pkt_item      it;
        t_window_result predicted;

        // empty window, unused kind, extremes, oversize clamp, duplicates,
        // repeated ack, fill to full, then one ack that drains across the wrap
        plan.push_back(trow(swt_pkg::KIND_ACK, 32'd5, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_EMPTY, 5'd0, 16'h0, 11'd0, 32'h0, 32'h0, 5'd0));
        plan.push_back(trow(swt_pkg::KIND_LOOKUP, 32'd0, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_EMPTY, 5'd0, 16'h0, 11'd0, 32'h0, 32'h0, 5'd0));
        plan.push_back(trow(KIND_UNUSED, 32'h1234_5678, 16'hA5A5, 11'd300, 32'hDEAD_BEEF,
                            swt_pkg::ST_OK, 5'd0, 16'h0, 11'd0, 32'h0, 32'h0, 5'd0));
        plan.push_back(trow(swt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 11'd1024,
                            32'hFFFF_FFFF, swt_pkg::ST_OK, 5'd0, 16'h0, 11'd0, 32'h0,
                            32'hFFFF_FFFF, 5'd1));
        plan.push_back(trow(swt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_OK, 5'd0, 16'hFFFF, 11'd1024, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 5'd1));
        plan.push_back(trow(swt_pkg::KIND_INSERT, 32'd0, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_OK, 5'd0, 16'h0, 11'd0, 32'h0, 32'hFFFF_FFFF,
                            5'd2));
        plan.push_back(row(swt_pkg::KIND_INSERT, 32'd7, 16'd1234, 11'd2047, 32'd55));
        plan.push_back(trow(swt_pkg::KIND_LOOKUP, 32'd7, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_OK, 5'd0, 16'd1234, 11'd1024, 32'd55,
                            32'hFFFF_FFFF, 5'd3));
        plan.push_back(trow(swt_pkg::KIND_LOOKUP, 32'd99, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_MISS, 5'd0, 16'h0, 11'd0, 32'h0, 32'hFFFF_FFFF,
                            5'd3));
        plan.push_back(row(swt_pkg::KIND_INSERT, 32'd7, 16'd2, 11'd5, 32'd9));
        plan.push_back(row(swt_pkg::KIND_ACK, 32'd0, 16'h0, 11'd0, 32'h0));
        plan.push_back(trow(swt_pkg::KIND_ACK, 32'd0, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_MISS, 5'd0, 16'h0, 11'd0, 32'h0, 32'hFFFF_FFFF,
                            5'd4));
        plan.push_back(row(swt_pkg::KIND_LOOKUP, 32'd0, 16'h0, 11'd0, 32'h0));
        plan.push_back(row(swt_pkg::KIND_LOOKUP, 32'd7, 16'h0, 11'd0, 32'h0));
        plan.push_back(row(swt_pkg::KIND_ACK, 32'hFFFF_FFFF, 16'h0, 11'd0, 32'h0));
        plan.push_back(row(KIND_UNUSED, 32'd7, 16'h1, 11'd1, 32'h1));
        plan.push_back(row(swt_pkg::KIND_ACK, 32'd7, 16'h0, 11'd0, 32'h0));
        plan.push_back(row(swt_pkg::KIND_INSERT, 32'd100, 16'h5555, 11'h2AA,
                           32'hAAAA_5555, 15));
        plan.push_back(trow(swt_pkg::KIND_INSERT, 32'd200, 16'h1, 11'd1, 32'h1,
                            swt_pkg::ST_FULL, 5'd0, 16'h0, 11'd0, 32'h0, 32'd7, 5'd16));
        plan.push_back(row(swt_pkg::KIND_ACK, 32'd100, 16'h0, 11'd0, 32'h0, 15));
        plan.push_back(trow(swt_pkg::KIND_ACK, 32'd7, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_OK, 5'd16, 16'h0, 11'd0, 32'h0, 32'h0, 5'd0));
        plan.push_back(trow(swt_pkg::KIND_ACK, 32'd7, 16'h0, 11'd0, 32'h0,
                            swt_pkg::ST_EMPTY, 5'd0, 16'h0, 11'd0, 32'h0, 32'h0, 5'd0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            for (int n = 0; n < plan[r].reps; n++) begin
                it     = plan[r].item;
                it.seq = it.seq + swt_pkg::SEQ_W'(n);
                send_item(it);
                predicted = window_step(it);
                expected_q.push_back(plan[r].typed ? plan[r].want : predicted);
            end
        end
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 1000);
            if (n % 300 == 299) begin
                hold_until_drained();
            end
            it = random_item((n / 90) % 2 == 0);
            send_item(it);
            expected_q.push_back(window_step(it));
        end
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts, %0d acks, %0d lookups and %0d unused-kind items.",
                 kind_tally[swt_pkg::KIND_INSERT], kind_tally[swt_pkg::KIND_ACK],
                 kind_tally[swt_pkg::KIND_LOOKUP], kind_tally[KIND_UNUSED]);
        $display("Checked %0d results: %0d full, %0d empty, %0d miss; widest head advance %0d.",
                 result_count, status_tally[swt_pkg::ST_FULL],
                 status_tally[swt_pkg::ST_EMPTY], status_tally[swt_pkg::ST_MISS], max_shift);
        if (err_count == 0) begin
            $display("send_window_table_top test passed");
        end else begin
            $display("send_window_table_top test failed");
        end
        $finish;
    end

endmodule
